// ===== src/phrs_pkg.sv =====
// Shared types, codes and reset values for the peer heartbeat recovery supervisor.
`default_nettype none

package phrs_pkg;

    localparam int TIME_W      = 32;
    localparam int CNT_W       = 32;
    localparam int TRIES_W     = 8;
    localparam int MODE_W      = 2;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Register reset values
    localparam logic [TIME_W-1:0]  HEARTBEAT_TIMEOUT_RST = 32'd1000;
    localparam logic [TIME_W-1:0]  RESET_HOLD_TIME_RST   = 32'd100;
    localparam logic [TIME_W-1:0]  BOOT_WAIT_TIME_RST    = 32'd500;
    localparam logic [TIME_W-1:0]  POWER_CYCLE_TIME_RST  = 32'd1000;
    localparam logic [TRIES_W-1:0] MAX_RESET_TRIES_RST   = 8'd3;

    // Event codes on the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 2'd0,
        MODE_BEAT    = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    // Classified commands handed from front to back
    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_BEAT,
        CMD_RESTART
    } cmd_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_HEALTHY    = 3'd0,
        PH_RESET_HELD = 3'd1,
        PH_BOOT_WAIT  = 3'd2,
        PH_POWER_WAIT = 3'd3,
        PH_FAILED     = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEARTBEAT_TIMEOUT = 3'd0,
        CFG_RESET_HOLD_TIME   = 3'd1,
        CFG_BOOT_WAIT_TIME    = 3'd2,
        CFG_POWER_CYCLE_TIME  = 3'd3,
        CFG_MAX_RESET_TRIES   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic               mute_audio;
        logic               assert_reset;
        logic               release_reset;
        logic               power_cycle;
        logic               report_fault;
        logic [PHASE_W-1:0] phase;
        logic [TRIES_W-1:0] tries_used;
        logic [CNT_W-1:0]   beats_seen;
        logic [CNT_W-1:0]   recoveries_seen;
        logic [CNT_W-1:0]   timeouts_seen;
        logic [CNT_W-1:0]   power_cycles_seen;
    } out_item_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [TIME_W-1:0] now_time;
    } cmd_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  heartbeat_timeout;
        logic [TIME_W-1:0]  reset_hold_time;
        logic [TIME_W-1:0]  boot_wait_time;
        logic [TIME_W-1:0]  power_cycle_time;
        logic [TRIES_W-1:0] max_reset_tries;
    } cfg_t;

    typedef struct packed {
        logic mute;
        logic assert_rst;
        logic release_rst;
        logic power;
        logic fault;
    } act_t;

endpackage

`default_nettype wire

// ===== src/phrs_front.sv =====
// Front stage: accepts input items and classifies them into commands.
`default_nettype none

module phrs_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire phrs_pkg::in_item_t  in_item,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output phrs_pkg::cmd_item_t      push_item
);
    import phrs_pkg::*;

    logic      front_valid_reg;
    logic      front_valid_next;
    cmd_item_t front_item_reg;
    cmd_item_t front_item_next;
    logic      accept;

    // Stall only while the held item cannot move on
    assign in_stall = front_valid_reg & ~push_ready;
    assign accept   = in_valid & ~in_stall;

    // Classify the event kind
    always_comb
    begin
        front_item_next.now_time = in_item.now_time;
        case (in_item.mode)
            MODE_TICK:    front_item_next.cmd = CMD_TICK;
            MODE_BEAT:    front_item_next.cmd = CMD_BEAT;
            MODE_RESTART: front_item_next.cmd = CMD_RESTART;
            default:      front_item_next.cmd = CMD_NOP;
        endcase
    end

    assign front_valid_next = accept | (front_valid_reg & ~push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // Capture the classified item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_item_reg <= front_item_next;
        end
    end

    assign push_valid = front_valid_reg;
    assign push_item  = front_item_reg;

endmodule

`default_nettype wire

// ===== src/phrs_queue.sv =====
// Short command queue between the front and the execution stage.
`default_nettype none

module phrs_queue #(
    parameter int DEPTH = phrs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire phrs_pkg::cmd_item_t  push_item,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output phrs_pkg::cmd_item_t       pop_item
);
    import phrs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    cmd_item_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                push;
    logic                pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push & ~pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop & ~push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/phrs_exec.sv =====
// Execution stage: recovery state machine, counters and the result register.
`default_nettype none

module phrs_exec (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire phrs_pkg::cfg_t       cfg,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire phrs_pkg::cmd_item_t  pop_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output phrs_pkg::out_item_t       out_item
);
    import phrs_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [TIME_W-1:0]  last_beat_reg;
    logic [TIME_W-1:0]  last_beat_next;
    logic [TIME_W-1:0]  phase_start_reg;
    logic [TIME_W-1:0]  phase_start_next;
    logic [TRIES_W-1:0] tries_reg;
    logic [TRIES_W-1:0] tries_next;
    logic [CNT_W-1:0]   beats_reg;
    logic [CNT_W-1:0]   beats_next;
    logic [CNT_W-1:0]   recov_reg;
    logic [CNT_W-1:0]   recov_next;
    logic [CNT_W-1:0]   timeouts_reg;
    logic [CNT_W-1:0]   timeouts_next;
    logic [CNT_W-1:0]   pcycles_reg;
    logic [CNT_W-1:0]   pcycles_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;

    logic               pop;
    logic [TIME_W-1:0]  since_phase;
    logic [TIME_W-1:0]  since_beat;
    logic               timed_out;
    logic               hold_done;
    logic               boot_done;
    logic               power_done;
    logic               retry_ok;
    act_t               act;

    // Take a command whenever the result register is free or being drained
    assign pop_ready = ~out_valid_reg | ~out_stall;
    assign pop       = pop_valid & pop_ready;

    // Wrapping time differences and threshold checks
    assign since_phase = pop_item.now_time - phase_start_reg;
    assign since_beat  = pop_item.now_time - last_beat_reg;
    assign timed_out   = since_beat > cfg.heartbeat_timeout;
    assign hold_done   = since_phase >= cfg.reset_hold_time;
    assign boot_done   = since_phase >= cfg.boot_wait_time;
    assign power_done  = since_phase >= cfg.power_cycle_time;
    assign retry_ok    = tries_reg < cfg.max_reset_tries;

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        last_beat_next   = last_beat_reg;
        phase_start_next = phase_start_reg;
        tries_next       = tries_reg;
        beats_next       = beats_reg;
        recov_next       = recov_reg;
        timeouts_next    = timeouts_reg;
        pcycles_next     = pcycles_reg;
        if (pop)
        begin
            case (pop_item.cmd)
                CMD_TICK:
                begin
                    case (phase_reg)
                        PH_HEALTHY:
                        begin
                            if (timed_out)
                            begin
                                timeouts_next    = timeouts_reg + 1'b1;
                                tries_next       = TRIES_W'(1);
                                phase_next       = PH_RESET_HELD;
                                phase_start_next = pop_item.now_time;
                            end
                        end
                        PH_RESET_HELD:
                        begin
                            if (hold_done)
                            begin
                                phase_next       = PH_BOOT_WAIT;
                                phase_start_next = pop_item.now_time;
                            end
                        end
                        PH_BOOT_WAIT:
                        begin
                            if (boot_done)
                            begin
                                phase_start_next = pop_item.now_time;
                                if (retry_ok)
                                begin
                                    tries_next = tries_reg + 1'b1;
                                    phase_next = PH_RESET_HELD;
                                end
                                else
                                begin
                                    pcycles_next = pcycles_reg + 1'b1;
                                    phase_next   = PH_POWER_WAIT;
                                end
                            end
                        end
                        PH_POWER_WAIT:
                        begin
                            if (power_done)
                            begin
                                phase_next       = PH_FAILED;
                                phase_start_next = pop_item.now_time;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                CMD_BEAT:
                begin
                    beats_next       = beats_reg + 1'b1;
                    last_beat_next   = pop_item.now_time;
                    phase_start_next = pop_item.now_time;
                    phase_next       = PH_HEALTHY;
                    tries_next       = '0;
                    if (phase_reg != PH_HEALTHY)
                    begin
                        recov_next = recov_reg + 1'b1;
                    end
                end
                CMD_RESTART:
                begin
                    beats_next       = '0;
                    recov_next       = '0;
                    timeouts_next    = '0;
                    pcycles_next     = '0;
                    tries_next       = '0;
                    last_beat_next   = pop_item.now_time;
                    phase_start_next = pop_item.now_time;
                    phase_next       = PH_HEALTHY;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Action flags for the current command
    always_comb
    begin
        act = '0;
        if (pop_item.cmd == CMD_TICK)
        begin
            case (phase_reg)
                PH_HEALTHY:
                begin
                    if (timed_out)
                    begin
                        act.mute       = 1'b1;
                        act.assert_rst = 1'b1;
                        act.fault      = 1'b1;
                    end
                end
                PH_RESET_HELD:
                begin
                    act.mute        = 1'b1;
                    act.release_rst = hold_done;
                end
                PH_BOOT_WAIT:
                begin
                    act.mute       = 1'b1;
                    act.assert_rst = boot_done & retry_ok;
                    act.power      = boot_done & ~retry_ok;
                    act.fault      = boot_done & ~retry_ok;
                end
                PH_POWER_WAIT:
                begin
                    act.mute  = 1'b1;
                    act.fault = power_done;
                end
                default:
                begin
                    act.mute  = 1'b1;
                    act.fault = 1'b1;
                end
            endcase
        end
    end

    // Assemble the result from the updated state
    always_comb
    begin
        out_item_next.mute_audio        = act.mute;
        out_item_next.assert_reset      = act.assert_rst;
        out_item_next.release_reset     = act.release_rst;
        out_item_next.power_cycle       = act.power;
        out_item_next.report_fault      = act.fault;
        out_item_next.phase             = phase_next;
        out_item_next.tries_used        = tries_next;
        out_item_next.beats_seen        = beats_next;
        out_item_next.recoveries_seen   = recov_next;
        out_item_next.timeouts_seen     = timeouts_next;
        out_item_next.power_cycles_seen = pcycles_next;
    end

    assign out_valid_next = pop | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEALTHY;
            last_beat_reg   <= '0;
            phase_start_reg <= '0;
            tries_reg       <= '0;
            beats_reg       <= '0;
            recov_reg       <= '0;
            timeouts_reg    <= '0;
            pcycles_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            last_beat_reg   <= last_beat_next;
            phase_start_reg <= phase_start_next;
            tries_reg       <= tries_next;
            beats_reg       <= beats_next;
            recov_reg       <= recov_next;
            timeouts_reg    <= timeouts_next;
            pcycles_reg     <= pcycles_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== src/peer_heartbeat_recovery_supervisor.sv =====
// Top level of the peer heartbeat recovery supervisor: config registers and stage wiring.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | in        | in_valid / in_stall  | in_item  (mode, now_time)
//   out     | out       | out_valid / out_stall| out_item (flags, phase, counters)
//   cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while the output does not stall; an accepted item passes
// through the front register, the queue and the result register.
// The execution stage updates all recovery state as it takes each item.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stall on the output fills the queue before the input stalls.
`default_nettype none

module peer_heartbeat_recovery_supervisor #(
    parameter int QUEUE_DEPTH = phrs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire phrs_pkg::in_item_t                 in_item,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output phrs_pkg::out_item_t                     out_item,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [phrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [phrs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import phrs_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      cfg_write;

    logic      push_valid;
    logic      push_ready;
    cmd_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    cmd_item_t pop_item;

    // Config writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // Decode register writes; drop writes beyond the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_HEARTBEAT_TIMEOUT: cfg_next.heartbeat_timeout = cfg_data;
                CFG_RESET_HOLD_TIME:   cfg_next.reset_hold_time   = cfg_data;
                CFG_BOOT_WAIT_TIME:    cfg_next.boot_wait_time    = cfg_data;
                CFG_POWER_CYCLE_TIME:  cfg_next.power_cycle_time  = cfg_data;
                CFG_MAX_RESET_TRIES:   cfg_next.max_reset_tries   = cfg_data[TRIES_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heartbeat_timeout <= HEARTBEAT_TIMEOUT_RST;
            cfg_reg.reset_hold_time   <= RESET_HOLD_TIME_RST;
            cfg_reg.boot_wait_time    <= BOOT_WAIT_TIME_RST;
            cfg_reg.power_cycle_time  <= POWER_CYCLE_TIME_RST;
            cfg_reg.max_reset_tries   <= MAX_RESET_TRIES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    phrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    phrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    phrs_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== src/phrs_checker.sv =====
// Port-level checker for the supervisor and its bind to the top level.
`default_nettype none

module phrs_checker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire phrs_pkg::out_item_t   out_item
);
    import phrs_pkg::*;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

    // Healthy results carry no actions
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.phase == PH_HEALTHY) |->
            !out_item.mute_audio && !out_item.assert_reset && !out_item.release_reset
            && !out_item.power_cycle && !out_item.report_fault)
    else $error("action flagged while healthy");

    // Reset assertion lands in the hold phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.assert_reset |->
            (out_item.phase == PH_RESET_HELD) && out_item.mute_audio
            && (out_item.tries_used != '0))
    else $error("assert_reset outside reset hold");

    // Release moves to boot wait
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.release_reset |->
            (out_item.phase == PH_BOOT_WAIT) && !out_item.assert_reset)
    else $error("release_reset outside boot wait");

    // Power cycle request enters power wait with a fault report
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.power_cycle |->
            (out_item.phase == PH_POWER_WAIT) && out_item.report_fault
            && (out_item.power_cycles_seen != '0))
    else $error("power_cycle outside power wait");

endmodule

bind peer_heartbeat_recovery_supervisor phrs_checker u_phrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire

// ===== dv/phrs_checker.sv =====
// Checker for the supervisor: tracks recovery state, predicts each status item and compares.
module phrs_tb_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  phrs_pkg::in_item_t              in_item,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  phrs_pkg::out_item_t             out_item,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [phrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phrs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import phrs_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Register copies
    logic [TIME_W-1:0]  hb_timeout;
    logic [TIME_W-1:0]  hold_ms;
    logic [TIME_W-1:0]  boot_ms;
    logic [TIME_W-1:0]  power_ms;
    logic [TRIES_W-1:0] max_tries;

    // Recovery state
    phase_t             cur_phase;
    logic [TIME_W-1:0]  last_beat_ms;
    logic [TIME_W-1:0]  phase_start_ms;
    logic [TRIES_W-1:0] tries_made;
    logic [CNT_W-1:0]   beat_cnt;
    logic [CNT_W-1:0]   recovery_cnt;
    logic [CNT_W-1:0]   timeout_cnt;
    logic [CNT_W-1:0]   power_cnt;

    out_item_t expected_status_q[$];

    function automatic string fmt_status(out_item_t s);
        return {$sformatf("mute %b assert %b release %b power %b fault %b ",
                          s.mute_audio, s.assert_reset, s.release_reset, s.power_cycle,
                          s.report_fault),
                $sformatf("phase %0d tries %0d beats %0d recov %0d timeouts %0d cycles %0d",
                          s.phase, s.tries_used, s.beats_seen, s.recoveries_seen,
                          s.timeouts_seen, s.power_cycles_seen)};
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Advance the recovery state by one event and build its status item
    task automatic predict_status(input in_item_t ev, output out_item_t res);
        act_t              act;
        logic [TIME_W-1:0] since_ms;
        logic [TIME_W-1:0] quiet_ms;
        act = '0;
        since_ms = ev.now_time - phase_start_ms;
        quiet_ms = ev.now_time - last_beat_ms;
        case (ev.mode)
            MODE_TICK:
            begin
                case (cur_phase)
                    PH_HEALTHY:
                    begin
                        if (quiet_ms > hb_timeout)
                        begin
                            timeout_cnt++;
                            tries_made = 8'd1;
                            cur_phase = PH_RESET_HELD;
                            phase_start_ms = ev.now_time;
                            act.mute = 1'b1;
                            act.assert_rst = 1'b1;
                            act.fault = 1'b1;
                        end
                    end
                    PH_RESET_HELD:
                    begin
                        act.mute = 1'b1;
                        if (since_ms >= hold_ms)
                        begin
                            cur_phase = PH_BOOT_WAIT;
                            phase_start_ms = ev.now_time;
                            act.release_rst = 1'b1;
                        end
                    end
                    PH_BOOT_WAIT:
                    begin
                        act.mute = 1'b1;
                        if (since_ms >= boot_ms)
                        begin
                            // Retry the reset until the attempt budget runs out
                            if (tries_made < max_tries)
                            begin
                                tries_made++;
                                cur_phase = PH_RESET_HELD;
                                act.assert_rst = 1'b1;
                            end
                            else
                            begin
                                power_cnt++;
                                cur_phase = PH_POWER_WAIT;
                                act.power = 1'b1;
                                act.fault = 1'b1;
                            end
                            phase_start_ms = ev.now_time;
                        end
                    end
                    PH_POWER_WAIT:
                    begin
                        act.mute = 1'b1;
                        if (since_ms >= power_ms)
                        begin
                            cur_phase = PH_FAILED;
                            phase_start_ms = ev.now_time;
                            act.fault = 1'b1;
                        end
                    end
                    default:
                    begin
                        act.mute = 1'b1;
                        act.fault = 1'b1;
                    end
                endcase
            end
            MODE_BEAT:
            begin
                beat_cnt++;
                last_beat_ms = ev.now_time;
                if (cur_phase != PH_HEALTHY)
                begin
                    recovery_cnt++;
                end
                cur_phase = PH_HEALTHY;
                phase_start_ms = ev.now_time;
                tries_made = '0;
            end
            MODE_RESTART:
            begin
                beat_cnt = '0;
                recovery_cnt = '0;
                timeout_cnt = '0;
                power_cnt = '0;
                tries_made = '0;
                last_beat_ms = ev.now_time;
                cur_phase = PH_HEALTHY;
                phase_start_ms = ev.now_time;
            end
            default:
            begin
            end
        endcase
        res.mute_audio = act.mute;
        res.assert_reset = act.assert_rst;
        res.release_reset = act.release_rst;
        res.power_cycle = act.power;
        res.report_fault = act.fault;
        res.phase = cur_phase;
        res.tries_used = tries_made;
        res.beats_seen = beat_cnt;
        res.recoveries_seen = recovery_cnt;
        res.timeouts_seen = timeout_cnt;
        res.power_cycles_seen = power_cnt;
    endtask

    // Watch the three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            hb_timeout = HEARTBEAT_TIMEOUT_RST;
            hold_ms = RESET_HOLD_TIME_RST;
            boot_ms = BOOT_WAIT_TIME_RST;
            power_ms = POWER_CYCLE_TIME_RST;
            max_tries = MAX_RESET_TRIES_RST;
            cur_phase = PH_HEALTHY;
            last_beat_ms = '0;
            phase_start_ms = '0;
            tries_made = '0;
            beat_cnt = '0;
            recovery_cnt = '0;
            timeout_cnt = '0;
            power_cnt = '0;
            expected_status_q.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            // Track register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HEARTBEAT_TIMEOUT: hb_timeout = cfg_data;
                    CFG_RESET_HOLD_TIME:   hold_ms = cfg_data;
                    CFG_BOOT_WAIT_TIME:    boot_ms = cfg_data;
                    CFG_POWER_CYCLE_TIME:  power_ms = cfg_data;
                    CFG_MAX_RESET_TRIES:   max_tries = cfg_data[TRIES_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_status(in_item, want);
                expected_status_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_status_q.size() == 0)
                begin
                    note_failure({"unexpected item: ", fmt_status(out_item)});
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    if (out_item !== want)
                    begin
                        note_failure($sformatf("mismatch\n  expected %s\n  actual   %s",
                                               fmt_status(want), fmt_status(out_item)));
                    end
                end
            end
            pending_count = expected_status_q.size();
        end
    end

endmodule

// ===== dv/tb_peer_heartbeat_recovery_supervisor.sv =====
// Testbench top for the supervisor: clock, reset, event stimulus, register settings, verdict.
module tb_peer_heartbeat_recovery_supervisor;
    timeunit 1ns;
    timeprecision 1ps;

    import phrs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE    = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_SPARE       = 2'd3;
    localparam logic [TIME_W-1:0]    TIME_MAX         = 32'hFFFF_FFFF;
    localparam int                   LONG_HOLD_CYCLES = 300;
    localparam int                   DRAIN_CYCLES     = 16;
    localparam int                   DRAIN_LIMIT      = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_count;

    logic [TIME_W-1:0]     cur_ms;
    int                    send_burst;
    bit                    hold_req;

    peer_heartbeat_recovery_supervisor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    phrs_tb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, free-running stretches and one long hold on request
    initial
    begin : status_receiver
        int r;
        int free_run;
        out_stall = 1'b0;
        free_run = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (free_run > 0)
            begin
                out_stall <= 1'b0;
                free_run--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    free_run = $urandom_range(20, 80);
                    out_stall <= 1'b0;
                end
                else if (r < 65)
                begin
                    out_stall <= 1'b0;
                end
                else if (r < 93)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(0, 2)) @(negedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(9, 39)) @(negedge clk);
                end
            end
        end
    end

    // Offer one event item, hold it until accepted, then idle for a random gap, which may be none
    task automatic send_event(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] t);
        in_item_t it;
        int       g;
        int       r;
        it.mode = m;
        it.now_time = t;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        r = $urandom_range(0, 99);
        g = 0;
        if (send_burst > 0)
        begin
            send_burst--;
        end
        else if (hold_req)
        begin
            g = 0;
        end
        else if (r < 3)
        begin
            send_burst = $urandom_range(20, 80);
        end
        else if (r < 60)
        begin
            g = 0;
        end
        else if (r < 88)
        begin
            g = $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            g = $urandom_range(4, 10);
        end
        else
        begin
            g = $urandom_range(20, 60);
        end
        if (g > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    // Drop the event valid and wait until every status item has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [TIME_W-1:0] timeout_ms,
                                 input logic [TIME_W-1:0] hold_ms,
                                 input logic [TIME_W-1:0] boot_ms,
                                 input logic [TIME_W-1:0] power_ms,
                                 input logic [TRIES_W-1:0] tries);
        wait_idle();
        write_reg(CFG_HEARTBEAT_TIMEOUT, timeout_ms);
        write_reg(CFG_RESET_HOLD_TIME, hold_ms);
        write_reg(CFG_BOOT_WAIT_TIME, boot_ms);
        write_reg(CFG_POWER_CYCLE_TIME, power_ms);
        write_reg(CFG_MAX_RESET_TRIES, {{(CFG_DATA_W-TRIES_W){1'b0}}, tries});
    endtask

    // Mostly ordered event streams on a running clock, with some noise mixed in
    task automatic run_events(input int n, input int unsigned scale, input bit do_hold,
                              input bit do_pause);
        int                r;
        int                d;
        logic [TIME_W-1:0] step_ms;
        for (int i = 0; i < n; i++)
        begin
            if (do_hold && i == n / 4)
            begin
                hold_req = 1'b1;
            end
            if (do_pause && i == n / 2)
            begin
                wait_idle();
            end
            d = $urandom_range(0, 9);
            if (d < 6)
            begin
                step_ms = $urandom_range(0, scale);
            end
            else if (d < 8)
            begin
                step_ms = $urandom_range(scale, 3 * scale);
            end
            else if (d < 9)
            begin
                step_ms = '0;
            end
            else
            begin
                step_ms = $urandom();
            end
            r = $urandom_range(0, 99);
            if (r < 93)
            begin
                cur_ms = cur_ms + step_ms;
            end
            if (r < 72)
            begin
                send_event(MODE_TICK, cur_ms);
            end
            else if (r < 86)
            begin
                send_event(MODE_BEAT, cur_ms);
            end
            else if (r < 89)
            begin
                send_event(MODE_RESTART, cur_ms);
            end
            else if (r < 93)
            begin
                send_event(MODE_SPARE, cur_ms);
            end
            else
            begin
                send_event(2'($urandom_range(0, 3)), $urandom());
            end
        end
    endtask

    initial
    begin : stimulus
        int drain;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_ms = '0;
        send_burst = 0;
        hold_req = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the whole escalation with the reset register values
        send_event(MODE_TICK, 32'd0);
        send_event(MODE_TICK, 32'd1000);
        send_event(MODE_TICK, 32'd1001);
        send_event(MODE_TICK, 32'd1100);
        send_event(MODE_TICK, 32'd1101);
        send_event(MODE_TICK, 32'd1600);
        send_event(MODE_TICK, 32'd1601);
        send_event(MODE_TICK, 32'd1701);
        send_event(MODE_TICK, 32'd2201);
        send_event(MODE_TICK, 32'd2301);
        send_event(MODE_TICK, 32'd2801);
        send_event(MODE_TICK, 32'd3800);
        send_event(MODE_TICK, 32'd3801);
        send_event(MODE_TICK, 32'd3802);
        send_event(MODE_SPARE, TIME_MAX);
        send_event(MODE_BEAT, 32'd4000);
        send_event(MODE_BEAT, 32'hFFFF_FF00);
        // Timeout measured across the wrap of the millisecond clock
        send_event(MODE_TICK, 32'h0000_02E8);
        send_event(MODE_TICK, 32'h0000_02E9);
        send_event(MODE_RESTART, TIME_MAX);
        send_event(MODE_TICK, 32'd0);
        send_event(MODE_BEAT, 32'd0);
        send_event(MODE_SPARE, 32'd0);
        cur_ms = '0;

        run_events(250, 600, 1'b1, 1'b1);

        // Zero registers: instant phase changes, a single reset attempt
        apply_setting('0, '0, '0, '0, '0);
        run_events(200, 4, 1'b0, 1'b0);

        // All registers at their maximum
        apply_setting(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, 8'hFF);
        run_events(150, 1000, 1'b0, 1'b0);

        // Quick timeout, then stuck in reset hold
        apply_setting(32'd1, TIME_MAX, TIME_MAX, TIME_MAX, 8'hFF);
        run_events(150, 5, 1'b0, 1'b0);

        apply_setting(32'd1, 32'd2, 32'd3, 32'd4, 8'd1);
        run_events(200, 6, 1'b1, 1'b0);

        for (int k = 0; k < 5; k++)
        begin
            apply_setting($urandom_range(0, 60), $urandom_range(0, 20), $urandom_range(0, 30),
                          $urandom_range(0, 40), 8'($urandom_range(0, 6)));
            if (k == 0)
            begin
                write_reg(CFG_IDX_SPARE, $urandom());
            end
            run_events(200, 40, 1'b0, k == 0);
        end

        // Long retry chains with short hold and boot times
        apply_setting(32'd30, 32'd0, 32'd1, 32'd0, 8'hFF);
        run_events(150, 3, 1'b0, 1'b0);

        // Drain, then let any stray items show up
        @(negedge clk);
        in_valid <= 1'b0;
        drain = 0;
        while (pending_count != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== peer_heartbeat_recovery_supervisor.f =====
src/phrs_pkg.sv
src/phrs_front.sv
src/phrs_queue.sv
src/phrs_exec.sv
src/peer_heartbeat_recovery_supervisor.sv
src/phrs_checker.sv
dv/phrs_checker.sv
dv/tb_peer_heartbeat_recovery_supervisor.sv
